### hw/rtl/pfdrc_pkg.sv
`timescale 1ns / 1ps
package pfdrc_pkg;

  localparam int DEPTH   = 1024;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int NODE_W  = 16;
  localparam int TIME_W  = 32;
  localparam int ENTRY_W = 2 * NODE_W + TIME_W;
  localparam int FUNC_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD   = 2'd0,
    FN_FWD   = 2'd1,
    FN_COUNT = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_COMMIT,
    ST_FWD_RD,
    ST_FWD_DATA,
    ST_DONE
  } state_t;

  // ring index advance, wraps at DEPTH
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

endpackage

### hw/rtl/pfdrc_ram.sv
`timescale 1ns / 1ps
module pfdrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/packet_fifo_dedup_range_count_core.sv
`timescale 1ns / 1ps
// Add and count walk every held entry through the packet RAM read port, one entry per
// cycle; on an empty store add and count read nothing.
// Forward reads one entry; forward on an empty store and func 3 read nothing.
// One item at a time; the result register lets the next item in while a result waits.
// Reset (rst_n low, synchronous) empties the store and sets memory_limit to 1024.
module packet_fifo_dedup_range_count_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfdrc_pkg::FUNC_W-1:0]  in_func,
  input  logic [pfdrc_pkg::NODE_W-1:0]  in_source_node,
  input  logic [pfdrc_pkg::NODE_W-1:0]  in_dest_node,
  input  logic [pfdrc_pkg::TIME_W-1:0]  in_time_stamp,
  input  logic [pfdrc_pkg::TIME_W-1:0]  in_range_start,
  input  logic [pfdrc_pkg::TIME_W-1:0]  in_range_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_added,
  output logic                          out_fwd_valid,
  output logic [pfdrc_pkg::NODE_W-1:0]  out_fwd_source,
  output logic [pfdrc_pkg::NODE_W-1:0]  out_fwd_dest,
  output logic [pfdrc_pkg::TIME_W-1:0]  out_fwd_time,
  output logic [pfdrc_pkg::CNT_W-1:0]   out_match_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfdrc_pkg::CNT_W-1:0]   cfg_memory_limit
);
  import pfdrc_pkg::*;

  state_t               state_r, state_nxt;
  logic [FUNC_W-1:0]    func_r, func_nxt;
  logic [NODE_W-1:0]    src_r, src_nxt;
  logic [NODE_W-1:0]    dst_r, dst_nxt;
  logic [TIME_W-1:0]    ts_r, ts_nxt;
  logic [TIME_W-1:0]    lo_r, lo_nxt;
  logic [TIME_W-1:0]    hi_r, hi_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     occ_r, occ_nxt;
  logic [CNT_W-1:0]     limit_r, limit_nxt;
  logic [CNT_W-1:0]     issue_r, issue_nxt;
  logic [PTR_W-1:0]     walk_ptr_r, walk_ptr_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic                 dup_r, dup_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 fwd_hit_r, fwd_hit_nxt;
  logic [ENTRY_W-1:0]   fwd_data_r, fwd_data_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_added_r, out_added_nxt;
  logic                 out_fwd_valid_r, out_fwd_valid_nxt;
  logic [NODE_W-1:0]    out_fwd_source_r, out_fwd_source_nxt;
  logic [NODE_W-1:0]    out_fwd_dest_r, out_fwd_dest_nxt;
  logic [TIME_W-1:0]    out_fwd_time_r, out_fwd_time_nxt;
  logic [CNT_W-1:0]     out_match_count_r, out_match_count_nxt;

  logic                 ram_we;
  logic [PTR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [PTR_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [CNT_W-1:0]     lim_eff;
  logic [ENTRY_W-1:0]   new_entry;
  logic                 rd_dest_hit;
  logic                 rd_time_hit;

  pfdrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_added       = out_added_r;
  assign out_fwd_valid   = out_fwd_valid_r;
  assign out_fwd_source  = out_fwd_source_r;
  assign out_fwd_dest    = out_fwd_dest_r;
  assign out_fwd_time    = out_fwd_time_r;
  assign out_match_count = out_match_count_r;

  // limit of 0 behaves as 1, anything above DEPTH as DEPTH
  always_comb begin
    if (limit_r == '0) begin
      lim_eff = CNT_W'(1);
    end else if (limit_r > CNT_W'(DEPTH)) begin
      lim_eff = CNT_W'(DEPTH);
    end else begin
      lim_eff = limit_r;
    end
  end

  assign new_entry   = {src_r, dst_r, ts_r};
  assign rd_dest_hit = (ram_rdata[TIME_W +: NODE_W] == dst_r);
  assign rd_time_hit = (ram_rdata[TIME_W-1:0] >= lo_r) && (ram_rdata[TIME_W-1:0] <= hi_r);

  always_comb begin
    state_nxt           = state_r;
    func_nxt            = func_r;
    src_nxt             = src_r;
    dst_nxt             = dst_r;
    ts_nxt              = ts_r;
    lo_nxt              = lo_r;
    hi_nxt              = hi_r;
    head_nxt            = head_r;
    tail_nxt            = tail_r;
    occ_nxt             = occ_r;
    limit_nxt           = limit_r;
    issue_nxt           = issue_r;
    walk_ptr_nxt        = walk_ptr_r;
    rd_vld_nxt          = 1'b0;
    dup_nxt             = dup_r;
    cnt_nxt             = cnt_r;
    fwd_hit_nxt         = fwd_hit_r;
    fwd_data_nxt        = fwd_data_r;
    out_valid_nxt       = out_valid_r;
    out_added_nxt       = out_added_r;
    out_fwd_valid_nxt   = out_fwd_valid_r;
    out_fwd_source_nxt  = out_fwd_source_r;
    out_fwd_dest_nxt    = out_fwd_dest_r;
    out_fwd_time_nxt    = out_fwd_time_r;
    out_match_count_nxt = out_match_count_r;
    ram_we              = 1'b0;
    ram_waddr           = tail_r;
    ram_wdata           = new_entry;
    ram_re              = 1'b0;
    ram_raddr           = walk_ptr_r;

    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_memory_limit;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt     = in_func;
          src_nxt      = in_source_node;
          dst_nxt      = in_dest_node;
          ts_nxt       = in_time_stamp;
          lo_nxt       = in_range_start;
          hi_nxt       = in_range_end;
          issue_nxt    = '0;
          walk_ptr_nxt = head_r;
          dup_nxt      = 1'b0;
          cnt_nxt      = '0;
          fwd_hit_nxt  = 1'b0;
          if (in_func == FN_ADD || in_func == FN_COUNT) begin
            state_nxt = ST_WALK;
          end else if (in_func == FN_FWD && occ_r != '0) begin
            state_nxt = ST_FWD_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        // one read issued per cycle, compare on the data in the next cycle
        if (issue_r != occ_r) begin
          ram_re       = 1'b1;
          ram_raddr    = walk_ptr_r;
          issue_nxt    = issue_r + CNT_W'(1);
          walk_ptr_nxt = next_ptr(walk_ptr_r);
          rd_vld_nxt   = 1'b1;
        end
        if (rd_vld_r) begin
          if (ram_rdata == new_entry) begin
            dup_nxt = 1'b1;
          end
          if (func_r == FN_COUNT && rd_dest_hit && rd_time_hit) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        if (issue_r == occ_r && !rd_vld_r) begin
          state_nxt = (func_r == FN_ADD) ? ST_COMMIT : ST_DONE;
        end
      end
      ST_COMMIT: begin
        if (!dup_r) begin
          ram_we    = 1'b1;
          ram_waddr = tail_r;
          tail_nxt  = next_ptr(tail_r);
          // full at or above the limit: oldest goes, so occupancy stays put
          if (occ_r >= lim_eff && occ_r != '0) begin
            head_nxt = next_ptr(head_r);
          end else begin
            occ_nxt = occ_r + CNT_W'(1);
          end
        end
        state_nxt = ST_DONE;
      end
      ST_FWD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = head_r;
        head_nxt  = next_ptr(head_r);
        occ_nxt   = occ_r - CNT_W'(1);
        state_nxt = ST_FWD_DATA;
      end
      ST_FWD_DATA: begin
        fwd_data_nxt = ram_rdata;
        fwd_hit_nxt  = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_added_nxt       = (func_r == FN_ADD) && !dup_r;
          out_fwd_valid_nxt   = fwd_hit_r;
          out_fwd_source_nxt  = fwd_hit_r ? fwd_data_r[TIME_W + NODE_W +: NODE_W] : '0;
          out_fwd_dest_nxt    = fwd_hit_r ? fwd_data_r[TIME_W +: NODE_W] : '0;
          out_fwd_time_nxt    = fwd_hit_r ? fwd_data_r[TIME_W-1:0] : '0;
          out_match_count_nxt = (func_r == FN_COUNT) ? cnt_r : '0;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      limit_r     <= CNT_W'(DEPTH);
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      limit_r     <= limit_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r            <= func_nxt;
    src_r             <= src_nxt;
    dst_r             <= dst_nxt;
    ts_r              <= ts_nxt;
    lo_r              <= lo_nxt;
    hi_r              <= hi_nxt;
    issue_r           <= issue_nxt;
    walk_ptr_r        <= walk_ptr_nxt;
    dup_r             <= dup_nxt;
    cnt_r             <= cnt_nxt;
    fwd_hit_r         <= fwd_hit_nxt;
    fwd_data_r        <= fwd_data_nxt;
    out_added_r       <= out_added_nxt;
    out_fwd_valid_r   <= out_fwd_valid_nxt;
    out_fwd_source_r  <= out_fwd_source_nxt;
    out_fwd_dest_r    <= out_fwd_dest_nxt;
    out_fwd_time_r    <= out_fwd_time_nxt;
    out_match_count_r <= out_match_count_nxt;
  end

endmodule

### hw/rtl/pfdrc_checker.sv
`timescale 1ns / 1ps
module pfdrc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [pfdrc_pkg::FUNC_W-1:0]  in_func,
  input  logic [pfdrc_pkg::NODE_W-1:0]  in_source_node,
  input  logic [pfdrc_pkg::NODE_W-1:0]  in_dest_node,
  input  logic [pfdrc_pkg::TIME_W-1:0]  in_time_stamp,
  input  logic [pfdrc_pkg::TIME_W-1:0]  in_range_start,
  input  logic [pfdrc_pkg::TIME_W-1:0]  in_range_end,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_added,
  input  logic                          out_fwd_valid,
  input  logic [pfdrc_pkg::NODE_W-1:0]  out_fwd_source,
  input  logic [pfdrc_pkg::NODE_W-1:0]  out_fwd_dest,
  input  logic [pfdrc_pkg::TIME_W-1:0]  out_fwd_time,
  input  logic [pfdrc_pkg::CNT_W-1:0]   out_match_count,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pfdrc_pkg::CNT_W-1:0]   cfg_memory_limit
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one item in flight: the transfer closes the input side for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  a_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fwd_valid |->
      out_fwd_source == '0 && out_fwd_dest == '0 && out_fwd_time == '0)
    else $error("forward fields nonzero without a popped packet");

  a_added_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_added |-> !out_fwd_valid && out_match_count == '0)
    else $error("add result mixed with other operations");

  a_fwd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fwd_valid |-> !out_added && out_match_count == '0)
    else $error("forward result mixed with other operations");

endmodule

bind packet_fifo_dedup_range_count_core pfdrc_checker u_pfdrc_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import pfdrc_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int QUIET_WAIT = 1100;
  localparam int RANDOM_PER_PHASE = 140;
  localparam int RECENT_KEEP = 32;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [TIME_W-1:0] ts;
  } packet_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    packet_t pkt;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
  } request_t;

  typedef struct packed {
    logic added;
    logic fwd_valid;
    packet_t fwd;
    logic [CNT_W-1:0] count;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [FUNC_W-1:0] in_func = '0;
  logic [NODE_W-1:0] in_source_node = '0;
  logic [NODE_W-1:0] in_dest_node = '0;
  logic [TIME_W-1:0] in_time_stamp = '0;
  logic [TIME_W-1:0] in_range_start = '0;
  logic [TIME_W-1:0] in_range_end = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CNT_W-1:0] cfg_memory_limit = '0;

  logic in_stall;
  logic out_valid;
  logic out_added;
  logic out_fwd_valid;
  logic [NODE_W-1:0] out_fwd_source;
  logic [NODE_W-1:0] out_fwd_dest;
  logic [TIME_W-1:0] out_fwd_time;
  logic [CNT_W-1:0] out_match_count;
  logic cfg_ready;

  // shadow of the packet store
  packet_t pkt_mem [DEPTH];
  int pkt_head = 0;
  int pkt_tail = 0;
  int pkt_occ = 0;
  logic [CNT_W-1:0] pkt_limit = CNT_W'(DEPTH);

  reply_t reply_q[$];
  packet_t recent_q[$];
  logic [TIME_W-1:0] ts_clock = 32'd100;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_left = 0;

  packet_fifo_dedup_range_count_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_source_node   (in_source_node),
    .in_dest_node     (in_dest_node),
    .in_time_stamp    (in_time_stamp),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_added        (out_added),
    .out_fwd_valid    (out_fwd_valid),
    .out_fwd_source   (out_fwd_source),
    .out_fwd_dest     (out_fwd_dest),
    .out_fwd_time     (out_fwd_time),
    .out_match_count  (out_match_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_memory_limit (cfg_memory_limit)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("packet_fifo_dedup_range_count_core test failed");
      $finish;
    end
  end

  // receiver: a pending hold-off wins over the random stall
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (err_cnt < PRINT_CAP) begin
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    end
    err_cnt++;
  endtask

  // updates the shadow store and returns what the block should answer
  function automatic reply_t store_reply(request_t rq);
    reply_t r;
    int lim;
    int p;
    int i;
    bit dup;
    r = '0;
    case (rq.func)
      FN_ADD: begin
        dup = 1'b0;
        p = pkt_head;
        for (i = 0; i < pkt_occ; i++) begin
          if (pkt_mem[p] == rq.pkt) dup = 1'b1;
          p = (p + 1) % DEPTH;
        end
        if (!dup) begin
          lim = pkt_limit;
          if (lim < 1) lim = 1;
          if (lim > DEPTH) lim = DEPTH;
          if (pkt_occ >= lim && pkt_occ > 0) begin
            pkt_head = (pkt_head + 1) % DEPTH;
            pkt_occ--;
          end
          pkt_mem[pkt_tail] = rq.pkt;
          pkt_tail = (pkt_tail + 1) % DEPTH;
          pkt_occ++;
          r.added = 1'b1;
        end
      end
      FN_FWD: begin
        if (pkt_occ > 0) begin
          r.fwd_valid = 1'b1;
          r.fwd = pkt_mem[pkt_head];
          pkt_head = (pkt_head + 1) % DEPTH;
          pkt_occ--;
        end
      end
      FN_COUNT: begin
        p = pkt_head;
        for (i = 0; i < pkt_occ; i++) begin
          if (pkt_mem[p].dst == rq.pkt.dst && pkt_mem[p].ts >= rq.lo &&
              pkt_mem[p].ts <= rq.hi) begin
            r.count++;
          end
          p = (p + 1) % DEPTH;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (reply_q.size() == 0) begin
        report_mismatch("result with nothing pending", 64'd0, 64'd0);
      end else begin
        want = reply_q.pop_front();
        if (out_added !== want.added)
          report_mismatch("added", out_added, want.added);
        if (out_fwd_valid !== want.fwd_valid)
          report_mismatch("fwd_valid", out_fwd_valid, want.fwd_valid);
        if (out_fwd_source !== want.fwd.src)
          report_mismatch("fwd_source", out_fwd_source, want.fwd.src);
        if (out_fwd_dest !== want.fwd.dst)
          report_mismatch("fwd_dest", out_fwd_dest, want.fwd.dst);
        if (out_fwd_time !== want.fwd.ts)
          report_mismatch("fwd_time", out_fwd_time, want.fwd.ts);
        if (out_match_count !== want.count)
          report_mismatch("match_count", out_match_count, want.count);
      end
    end
  end

  function automatic request_t make_req(logic [FUNC_W-1:0] func, logic [NODE_W-1:0] src,
                                        logic [NODE_W-1:0] dst, logic [TIME_W-1:0] ts,
                                        logic [TIME_W-1:0] lo, logic [TIME_W-1:0] hi);
    request_t rq;
    rq.func = func;
    rq.pkt.src = src;
    rq.pkt.dst = dst;
    rq.pkt.ts = ts;
    rq.lo = lo;
    rq.hi = hi;
    return rq;
  endfunction

  // called just after the clock rises; returns once the transfer has taken place
  task automatic send_request(request_t rq);
    int gap;
    reply_t exp_r;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= rq.func;
    in_source_node <= rq.pkt.src;
    in_dest_node <= rq.pkt.dst;
    in_time_stamp <= rq.pkt.ts;
    in_range_start <= rq.lo;
    in_range_end <= rq.hi;
    do @(posedge clk); while (in_stall !== 1'b0);
    exp_r = store_reply(rq);
    reply_q = {reply_q, exp_r};
  endtask

  task automatic settle();
    if (in_valid !== 1'b0) in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] value);
    settle();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_memory_limit <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    pkt_limit = value;
  endtask

  // half of them adds over a small key space so duplicates and matches are common
  function automatic request_t random_request();
    request_t rq;
    int sel;
    rq = make_req(FN_ADD, NODE_W'($urandom), NODE_W'($urandom), $urandom, $urandom,
                  $urandom);
    sel = $urandom_range(99);
    if (sel < 5) begin
      rq.func = FN_UNUSED;
    end else if (sel < 55) begin
      if (recent_q.size() > 0 && $urandom_range(3) == 0) begin
        rq.pkt = recent_q[$urandom_range(recent_q.size() - 1)];
      end else begin
        if ($urandom_range(4) != 0) rq.pkt.src = NODE_W'($urandom_range(3));
        if ($urandom_range(4) != 0) rq.pkt.dst = NODE_W'($urandom_range(3));
        if ($urandom_range(6) != 0) begin
          ts_clock += $urandom_range(2);
          rq.pkt.ts = ts_clock;
        end
        recent_q = {recent_q, rq.pkt};
        if (recent_q.size() > RECENT_KEEP) void'(recent_q.pop_front());
      end
    end else if (sel < 75) begin
      rq.func = FN_FWD;
    end else begin
      rq.func = FN_COUNT;
      if (recent_q.size() > 0 && $urandom_range(3) != 0)
        rq.pkt.dst = recent_q[$urandom_range(recent_q.size() - 1)].dst;
      else if ($urandom_range(3) != 0)
        rq.pkt.dst = NODE_W'($urandom_range(3));
      case ($urandom_range(3))
        0: begin
          rq.lo = '0;
          rq.hi = '1;
        end
        1: begin
          rq.lo = ts_clock - $urandom_range(8);
          rq.hi = rq.lo + $urandom_range(8);
        end
        2: begin
          // reversed bounds
          rq.lo = ts_clock - $urandom_range(4);
          rq.hi = rq.lo - 1 - $urandom_range(4);
        end
        default: ;
      endcase
    end
    return rq;
  endfunction

  task automatic test_empty_store();
    send_request(make_req(FN_FWD, '1, '1, '1, '1, '1));
    send_request(make_req(FN_COUNT, '0, '0, '0, '0, '1));
    send_request(make_req(FN_UNUSED, '1, '1, '1, '1, '1));
    settle();
  endtask

  task automatic test_add_and_count();
    send_request(make_req(FN_ADD, '0, '0, '0, $urandom, $urandom));
    send_request(make_req(FN_ADD, '1, '1, '1, $urandom, $urandom));
    send_request(make_req(FN_ADD, '1, '0, '1, '0, '1));
    send_request(make_req(FN_ADD, '0, '1, '0, '1, '0));
    send_request(make_req(FN_ADD, '1, '1, '1, '0, '0));   // duplicate
    send_request(make_req(FN_ADD, '0, '0, 32'd1, '0, '0));
    send_request(make_req(FN_COUNT, '0, '1, '0, '0, '1));
    send_request(make_req(FN_COUNT, '0, '1, '0, '1, '1));
    send_request(make_req(FN_COUNT, '0, '0, '0, '1, '0));
    send_request(make_req(FN_COUNT, '0, '0, '0, 32'd1, 32'd1));
    send_request(make_req(FN_UNUSED, NODE_W'($urandom), NODE_W'($urandom), $urandom,
                          $urandom, $urandom));
    settle();
  endtask

  // five held packets, so the first write lowers the limit below occupancy
  task automatic test_limit_drop();
    write_limit(11'd2);
    send_request(make_req(FN_ADD, 16'h1234, 16'h0005, 32'h10, '0, '0));
    send_request(make_req(FN_ADD, 16'h1235, 16'h0005, 32'h11, '0, '0));
    send_request(make_req(FN_FWD, '0, '0, '0, '0, '0));
    send_request(make_req(FN_FWD, '0, '0, '0, '0, '0));
    write_limit(11'd0);
    send_request(make_req(FN_ADD, 16'h00aa, 16'h0001, 32'h20, '0, '0));
    send_request(make_req(FN_FWD, '0, '0, '0, '0, '0));
    send_request(make_req(FN_FWD, '0, '0, '0, '0, '0));
    write_limit(CNT_W'(DEPTH));
  endtask

  task automatic test_backpressure();
    hold_left = 300;
    repeat (10) send_request(random_request());
    settle();
  endtask

  task automatic test_random_phase(logic [CNT_W-1:0] limit, int idle_pct, int stall_pct);
    write_limit(limit);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    repeat (RANDOM_PER_PHASE) send_request(random_request());
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_add_and_count();
    test_limit_drop();
    test_backpressure();
    test_random_phase(11'd2047, 0, 0);
    test_random_phase(11'd5, 61, 0);
    test_random_phase(11'd0, 0, 61);
    test_random_phase(CNT_W'($urandom_range(2, DEPTH - 1)), 27, 27);
    settle();
    repeat (QUIET_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("packet_fifo_dedup_range_count_core test passed");
    end else begin
      $display("packet_fifo_dedup_range_count_core test failed");
    end
    $finish;
  end

endmodule
